// ----- hdl/mab64_pkg.sv -----
// Shared types and constants for the 64-bit Barrett modular arithmetic unit.
`default_nettype none
package mab64_pkg;

  localparam int unsigned WORD_W     = 64;
  localparam int unsigned HALF_W     = 32;
  localparam int unsigned RES_W      = 63;
  localparam int unsigned SHIFT_W    = 6;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned DIV_STAGES = WORD_W;

  typedef enum logic [3:0] {
    OP_MUL       = 4'd0,
    OP_MUL_ADD   = 4'd1,
    OP_MUL_SUB   = 4'd2,
    OP_SCALE     = 4'd3,
    OP_SCALE_ADD = 4'd4,
    OP_ADD       = 4'd5,
    OP_SUB       = 4'd6,
    OP_NEG       = 4'd7,
    OP_ADD_S     = 4'd8,
    OP_SUB_S     = 4'd9,
    OP_RED       = 4'd10,
    OP_RED_S     = 4'd11
  } op_t;

  localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BFACTOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PSHIFT  = 2'd2;

  localparam logic [RES_W-1:0]   MODULUS_RST = 63'd2;
  localparam logic [WORD_W-1:0]  BFACTOR_RST = 64'd0;
  localparam logic [SHIFT_W-1:0] PSHIFT_RST  = 6'd1;

  // One transaction as it travels down the pipeline.
  typedef struct packed {
    op_t              op;
    logic             neg;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [RES_W-1:0]  acc;
    logic              last;
  } item_t;

endpackage
`default_nettype wire

// ----- hdl/mab64_in_if.sv -----
// Input channel: operation, operands, accumulator and end-of-vector mark.
`default_nettype none
interface mab64_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  operation;
  logic [63:0] operand_a;
  logic [63:0] operand_b;
  logic [62:0] accumulator;
  logic        last_in;

  modport source (output valid, operation, operand_a, operand_b, accumulator, last_in,
                  input ready);
  modport sink (input valid, operation, operand_a, operand_b, accumulator, last_in,
                output ready);
endinterface
`default_nettype wire

// ----- hdl/mab64_out_if.sv -----
// Output channel: residue and end-of-vector mark.
`default_nettype none
interface mab64_out_if;
  logic        valid;
  logic        ready;
  logic [62:0] residue;
  logic        last_out;

  modport source (output valid, residue, last_out, input ready);
  modport sink (input valid, residue, last_out, output ready);
endinterface
`default_nettype wire

// ----- hdl/mab64_div.sv -----
// Pipelined restoring remainder unit: one dividend bit per stage.
`default_nettype none
module mab64_div import mab64_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  item_t             in_item,
  input  logic [RES_W-1:0]  q,
  output logic              out_valid,
  output item_t             out_item,
  output logic [WORD_W-1:0] out_rem
);

  logic [DIV_STAGES-1:0] vld;
  item_t                 pl  [DIV_STAGES];
  logic [WORD_W-1:0]     rem [DIV_STAGES];

  genvar k;
  generate
    for (k = 0; k < DIV_STAGES; k++) begin : g_stage
      logic              prev_valid;
      item_t             prev_item;
      logic [WORD_W:0]   t;
      logic [WORD_W:0]   t_sub;
      logic [WORD_W-1:0] rem_next;

      if (k == 0) begin : g_first
        assign prev_valid = in_valid;
        assign prev_item  = in_item;
        assign t          = {{WORD_W{1'b0}}, in_item.b[WORD_W-1]};
      end else begin : g_rest
        assign prev_valid = vld[k-1];
        assign prev_item  = pl[k-1];
        assign t          = {rem[k-1], pl[k-1].b[WORD_W-1-k]};
      end

      // With a zero modulus nothing is subtracted and the dividend passes through.
      assign t_sub    = t - {2'b00, q};
      assign rem_next = (t >= {2'b00, q}) ? t_sub[WORD_W-1:0] : t[WORD_W-1:0];

      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k] <= 1'b0;
        end else if (en) begin
          vld[k] <= prev_valid;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          pl[k]  <= prev_item;
          rem[k] <= rem_next;
        end
      end
    end
  endgenerate

  assign out_valid = vld[DIV_STAGES-1];
  assign out_item  = pl[DIV_STAGES-1];
  assign out_rem   = rem[DIV_STAGES-1];

  a_div_hold: assert property (@(posedge clk) disable iff (rst) !en |=> $stable(vld))
    else $error("divider stages moved while stalled");
  a_div_enter: assert property (@(posedge clk) disable iff (rst) en && in_valid |=> vld[0])
    else $error("accepted transaction missing from first divider stage");
  a_div_rst: assert property (@(posedge clk) rst |=> vld == '0)
    else $error("divider valid bits not cleared by reset");

endmodule
`default_nettype wire

// ----- hdl/modular_arith_unit_barrett64_unit.sv -----
// Top level: 64-bit Barrett modular arithmetic pipeline.
//
//  channel  dir  handshake          payload
//  req      in   valid / ready      operation, operand_a, operand_b, accumulator, last_in
//  rsp      out  valid / ready      residue, last_out
//  cfg      in   cfg_we             cfg_index, cfg_data
//
// One transaction per cycle while rsp is not stalled: 64 remainder stages for the
// scalar reduction, then 11 stages of multiply, Barrett estimate and correction.
// The whole pipeline advances together; a stalled rsp freezes every stage, and
// req.ready drops only while the output register holds an untaken result.
// Reset clears all valid bits and loads the register defaults.
`default_nettype none
module modular_arith_unit_barrett64_unit import mab64_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  mab64_in_if.sink             req,
  mab64_out_if.source          rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data
);

  typedef enum logic [1:0] {MODE_PLAIN, MODE_ADD, MODE_SUB} mode_t;

  logic [RES_W-1:0]   modulus;
  logic [WORD_W-1:0]  bfactor;
  logic [SHIFT_W-1:0] pshift;
  logic [WORD_W-1:0]  q64;
  logic               adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MODULUS_RST;
      bfactor <= BFACTOR_RST;
      pshift  <= PSHIFT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODULUS: modulus <= cfg_data[RES_W-1:0];
        REG_BFACTOR: bfactor <= cfg_data;
        REG_PSHIFT:  pshift  <= cfg_data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  assign q64 = {1'b0, modulus};

  logic v_m1, v_m2, v_m3, v_m4, v_m5, v_m6, v_m7, v_m8, v_m9, v_f1, v_f2;
  assign adv       = !v_f2 || rsp.ready;
  assign req.ready = adv;

  // Remainder stages
  item_t             in_item;
  logic              d_valid;
  item_t             d_item;
  logic [WORD_W-1:0] d_rem;

  always_comb begin
    in_item      = '0;
    in_item.op   = op_t'(req.operation);
    in_item.neg  = 1'b0;
    in_item.a    = req.operand_a;
    in_item.b    = req.operand_b;
    in_item.acc  = req.accumulator;
    in_item.last = req.last_in;
  end

  mab64_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (req.valid),
    .in_item  (in_item),
    .q        (modulus),
    .out_valid(d_valid),
    .out_item (d_item),
    .out_rem  (d_rem)
  );

  // M1: operand select, signed magnitude, four partial products
  item_t             c_m1;
  logic [WORD_W-1:0] pp_ll, pp_lh, pp_hl, pp_hh;
  item_t             m1_item;
  logic [WORD_W-1:0] m1_y;
  logic              m1_scalar;

  always_comb begin
    m1_scalar = (d_item.op == OP_SCALE) || (d_item.op == OP_SCALE_ADD) ||
                (d_item.op == OP_ADD_S) || (d_item.op == OP_SUB_S);
    m1_y      = m1_scalar ? d_rem : d_item.b;
    m1_item   = d_item;
    m1_item.b = m1_y;
    m1_item.neg = (d_item.op == OP_RED_S) && d_item.a[WORD_W-1];
    if (m1_item.neg) begin
      m1_item.a = WORD_W'(0) - d_item.a;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_m1  <= m1_item;
      pp_ll <= {32'd0, d_item.a[HALF_W-1:0]}      * {32'd0, m1_y[HALF_W-1:0]};
      pp_lh <= {32'd0, d_item.a[HALF_W-1:0]}      * {32'd0, m1_y[WORD_W-1:HALF_W]};
      pp_hl <= {32'd0, d_item.a[WORD_W-1:HALF_W]} * {32'd0, m1_y[HALF_W-1:0]};
      pp_hh <= {32'd0, d_item.a[WORD_W-1:HALF_W]} * {32'd0, m1_y[WORD_W-1:HALF_W]};
    end
  end

  // M2: full 128-bit product
  item_t               c_m2;
  logic [2*WORD_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (adv) begin
      c_m2 <= c_m1;
      prod <= {pp_hh, 64'd0} + {32'd0, pp_lh, 32'd0} + {32'd0, pp_hl, 32'd0} +
              {64'd0, pp_ll};
    end
  end

  // M3: value to reduce and shifted Barrett input
  item_t               c_m3;
  logic [WORD_W-1:0]   v_m3_val, c_m3_val;
  logic                m3_reduce;
  logic [2*WORD_W-1:0] m3_src, m3_shifted;

  always_comb begin
    m3_reduce  = (c_m2.op == OP_RED) || (c_m2.op == OP_RED_S);
    m3_src     = m3_reduce ? {64'd0, c_m2.a} : prod;
    m3_shifted = m3_src >> pshift;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_m3     <= c_m2;
      v_m3_val <= m3_reduce ? c_m2.a : prod[WORD_W-1:0];
      c_m3_val <= m3_shifted[WORD_W-1:0];
    end
  end

  // M4: partials of the approximate high half
  item_t             c_m4;
  logic [WORD_W-1:0] v_m4_val, bf_lh, bf_hl, bf_hh;

  always_ff @(posedge clk) begin
    if (adv) begin
      c_m4     <= c_m3;
      v_m4_val <= v_m3_val;
      bf_lh    <= {32'd0, c_m3_val[HALF_W-1:0]}      * {32'd0, bfactor[WORD_W-1:HALF_W]};
      bf_hl    <= {32'd0, c_m3_val[WORD_W-1:HALF_W]} * {32'd0, bfactor[HALF_W-1:0]};
      bf_hh    <= {32'd0, c_m3_val[WORD_W-1:HALF_W]} * {32'd0, bfactor[WORD_W-1:HALF_W]};
    end
  end

  // M5: quotient estimate (low-by-low partial dropped)
  item_t             c_m5;
  logic [WORD_W-1:0] v_m5_val, est, m5_mid;

  assign m5_mid = bf_hl + {32'd0, bf_lh[HALF_W-1:0]};

  always_ff @(posedge clk) begin
    if (adv) begin
      c_m5     <= c_m4;
      v_m5_val <= v_m4_val;
      est      <= bf_hh + {32'd0, bf_lh[WORD_W-1:HALF_W]} + {32'd0, m5_mid[WORD_W-1:HALF_W]};
    end
  end

  // M6: partials of est * q, low word only
  item_t             c_m6;
  logic [WORD_W-1:0] v_m6_val, eq_ll, eq_lh, eq_hl;

  always_ff @(posedge clk) begin
    if (adv) begin
      c_m6     <= c_m5;
      v_m6_val <= v_m5_val;
      eq_ll    <= {32'd0, est[HALF_W-1:0]} * {32'd0, modulus[HALF_W-1:0]};
      eq_lh    <= {32'd0, est[HALF_W-1:0]} * {33'd0, modulus[RES_W-1:HALF_W]};
      eq_hl    <= {32'd0, est[WORD_W-1:HALF_W]} * {32'd0, modulus[HALF_W-1:0]};
    end
  end

  // M7: raw remainder, wraps mod 2^64
  item_t             c_m7;
  logic [WORD_W-1:0] rraw;
  logic [HALF_W-1:0] m7_cross;

  assign m7_cross = eq_lh[HALF_W-1:0] + eq_hl[HALF_W-1:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      c_m7 <= c_m6;
      rraw <= v_m6_val - (eq_ll + {m7_cross, 32'd0});
    end
  end

  // M8, M9: fold by 2q, then by q
  item_t             c_m8, c_m9;
  logic [WORD_W-1:0] fold1, fold2, m8_diff, m9_diff;

  assign m8_diff = rraw - {modulus, 1'b0};
  assign m9_diff = fold1 - q64;

  always_ff @(posedge clk) begin
    if (adv) begin
      c_m8  <= c_m7;
      fold1 <= (m8_diff < rraw) ? m8_diff : rraw;
      c_m9  <= c_m8;
      fold2 <= (m9_diff < fold1) ? m9_diff : fold1;
    end
  end

  // F1: pick operands per operation, one add or subtract
  mode_t             f1_mode, f1_mode_next;
  logic [WORD_W-1:0] f1_val;
  logic              f1_last;
  logic [WORD_W-1:0] f1_x, f1_y, acc64;
  logic              f1_is_add;

  assign acc64 = {1'b0, c_m9.acc};

  always_comb begin
    f1_x         = '0;
    f1_y         = '0;
    f1_mode_next = MODE_PLAIN;
    f1_is_add    = 1'b0;
    case (c_m9.op)
      OP_MUL, OP_SCALE, OP_RED: begin
        f1_x = fold2;
      end
      OP_MUL_ADD, OP_SCALE_ADD: begin
        f1_x = acc64; f1_y = fold2; f1_mode_next = MODE_ADD; f1_is_add = 1'b1;
      end
      OP_MUL_SUB: begin
        f1_x = acc64; f1_y = fold2; f1_mode_next = MODE_SUB;
      end
      OP_ADD, OP_ADD_S: begin
        f1_x = c_m9.a; f1_y = c_m9.b; f1_mode_next = MODE_ADD; f1_is_add = 1'b1;
      end
      OP_SUB, OP_SUB_S: begin
        f1_x = c_m9.a; f1_y = c_m9.b; f1_mode_next = MODE_SUB;
      end
      OP_NEG: begin
        // zero stays zero
        if (c_m9.a != '0) begin
          f1_x = q64; f1_y = c_m9.a;
        end
      end
      OP_RED_S: begin
        if (c_m9.neg && fold2 != '0) begin
          f1_x = q64; f1_y = fold2;
        end else begin
          f1_x = fold2;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_mode <= f1_mode_next;
      f1_val  <= f1_is_add ? (f1_x + f1_y) : (f1_x - f1_y);
      f1_last <= c_m9.last;
    end
  end

  // F2: final correction into the output register
  logic [WORD_W-1:0] f2_res, f2_sub_q, f2_add_q;
  logic              f2_last;

  assign f2_sub_q = f1_val - q64;
  assign f2_add_q = f1_val + q64;

  always_ff @(posedge clk) begin
    if (adv) begin
      f2_last <= f1_last;
      case (f1_mode)
        MODE_ADD: f2_res <= (f2_sub_q < f1_val) ? f2_sub_q : f1_val;
        MODE_SUB: f2_res <= f1_val[WORD_W-1] ? f2_add_q : f1_val;
        default:  f2_res <= f1_val;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_m1 <= 1'b0; v_m2 <= 1'b0; v_m3 <= 1'b0; v_m4 <= 1'b0;
      v_m5 <= 1'b0; v_m6 <= 1'b0; v_m7 <= 1'b0; v_m8 <= 1'b0;
      v_m9 <= 1'b0; v_f1 <= 1'b0; v_f2 <= 1'b0;
    end else if (adv) begin
      v_m1 <= d_valid; v_m2 <= v_m1; v_m3 <= v_m2; v_m4 <= v_m3;
      v_m5 <= v_m4; v_m6 <= v_m5; v_m7 <= v_m6; v_m8 <= v_m7;
      v_m9 <= v_m8; v_f1 <= v_m9; v_f2 <= v_f1;
    end
  end

  assign rsp.valid    = v_f2;
  assign rsp.residue  = f2_res[RES_W-1:0];
  assign rsp.last_out = f2_last;

  a_rst_clear: assert property (@(posedge clk)
      rst |=> !v_f2 && !v_f1 && !v_m1)
    else $error("pipeline valid bits not cleared by reset");
  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
      !adv |=> $stable(v_f1) && $stable(v_m9) && $stable(f2_res))
    else $error("pipeline moved while output stalled");
  a_add_mode: assert property (@(posedge clk) disable iff (rst)
      v_m9 && adv && f1_is_add |=> f1_mode == MODE_ADD)
    else $error("add selection and correction mode disagree");
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
      v_f2 && !rsp.ready |-> !req.ready)
    else $error("input taken while output register blocked");

endmodule
`default_nettype wire

// ----- tb/modular_arith_unit_barrett64_unit_tb.sv -----
// Self-checking testbench for the 64-bit Barrett modular arithmetic unit.
`timescale 1ns / 100ps
module modular_arith_unit_barrett64_unit_tb;
  import mab64_pkg::*;

  typedef struct {
    logic [RES_W-1:0] residue;
    logic             last;
  } residue_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WORD_W-1:0]    cfg_data  = '0;

  mab64_in_if  req ();
  mab64_out_if rsp ();

  modular_arith_unit_barrett64_unit u_dut (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Local copy of the register file.
  logic [WORD_W-1:0]  cur_q;
  logic [WORD_W-1:0]  cur_factor;
  logic [SHIFT_W-1:0] cur_shift;

  residue_t pending_residues[$];
  int err_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] approx_high(logic [63:0] x, logic [63:0] y);
    logic [63:0] lh, hl, hh, mid2;
    lh = {32'd0, x[31:0]} * {32'd0, y[63:32]};
    hl = {32'd0, x[63:32]} * {32'd0, y[31:0]};
    hh = {32'd0, x[63:32]} * {32'd0, y[63:32]};
    mid2 = hl + {32'd0, lh[31:0]};
    return hh + (lh >> 32) + (mid2 >> 32);
  endfunction

  function automatic logic [63:0] umin(logic [63:0] x, logic [63:0] y);
    return (x < y) ? x : y;
  endfunction

  function automatic logic [63:0] barrett_fold(logic [63:0] c, logic [63:0] v);
    logic [63:0] r;
    r = v - approx_high(c, cur_factor) * cur_q;
    r = umin(r, r - (cur_q << 1));
    return umin(r, r - cur_q);
  endfunction

  function automatic logic [63:0] mod_product(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    logic [127:0] ps;
    p = {64'd0, a} * {64'd0, b};
    ps = p >> cur_shift;
    return barrett_fold(ps[63:0], p[63:0]);
  endfunction

  function automatic logic [63:0] scalar_mod(logic [63:0] s);
    return (cur_q == 0) ? s : s % cur_q;
  endfunction

  function automatic logic [63:0] add_mod(logic [63:0] x, logic [63:0] y);
    logic [63:0] r;
    r = x + y;
    return umin(r, r - cur_q);
  endfunction

  function automatic logic [63:0] sub_mod(logic [63:0] x, logic [63:0] y);
    logic [63:0] d;
    d = x - y;
    return d[63] ? d + cur_q : d;
  endfunction

  function automatic logic [RES_W-1:0] predict_residue(logic [3:0] op, logic [63:0] a,
                                                       logic [63:0] b, logic [62:0] acc);
    logic [63:0] r, mag, acc64;
    acc64 = {1'b0, acc};
    r = 0;
    case (op)
      OP_MUL:       r = mod_product(a, b);
      OP_MUL_ADD:   r = add_mod(acc64, mod_product(a, b));
      OP_MUL_SUB:   r = sub_mod(acc64, mod_product(a, b));
      OP_SCALE:     r = mod_product(a, scalar_mod(b));
      OP_SCALE_ADD: r = add_mod(acc64, mod_product(a, scalar_mod(b)));
      OP_ADD:       r = add_mod(a, b);
      OP_SUB:       r = sub_mod(a, b);
      OP_NEG:       r = (a == 0) ? 64'd0 : cur_q - a;
      OP_ADD_S:     r = add_mod(a, scalar_mod(b));
      OP_SUB_S:     r = sub_mod(a, scalar_mod(b));
      OP_RED:       r = barrett_fold(a >> cur_shift, a);
      OP_RED_S: begin
        mag = a[63] ? 64'd0 - a : a;
        r = barrett_fold(mag >> cur_shift, mag);
        if (a[63] && r != 0) r = cur_q - r;
      end
      default:      r = 0;
    endcase
    return r[62:0];
  endfunction

  // Drive one transaction; valid stays high across back-to-back items.
  task automatic send_item(logic [3:0] op, logic [63:0] a, logic [63:0] b,
                           logic [62:0] acc, logic last);
    residue_t e;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid       <= 1'b1;
    req.operation   <= op;
    req.operand_a   <= a;
    req.operand_b   <= b;
    req.accumulator <= acc;
    req.last_in     <= last;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    e.residue = predict_residue(op, a, b, acc);
    e.last = last;
    pending_residues.push_back(e);
  endtask

  task automatic drain();
    @(negedge clk);
    req.valid <= 1'b0;
    while (pending_residues.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MODULUS: cur_q = {1'b0, value[62:0]};
      REG_BFACTOR: cur_factor = value;
      REG_PSHIFT:  cur_shift = value[5:0];
      default: ;
    endcase
  endtask

  // Load q with the factor floor(2^(64+s)/q), s = bit length of q minus one.
  task automatic load_modulus(logic [62:0] q);
    int s;
    logic [127:0] f;
    s = 0;
    for (int i = 0; i < 63; i++) if (q[i]) s = i;
    f = (128'd1 << (64 + s)) / {65'd0, q};
    write_register(REG_MODULUS, {1'b0, q});
    write_register(REG_BFACTOR, f[63:0]);
    write_register(REG_PSHIFT, 64'(s));
  endtask

  function automatic logic [63:0] pick_operand();
    int k;
    k = $urandom_range(99);
    if (k < 5) return 64'd0;
    if (k < 10) return (cur_q == 0) ? 64'd0 : cur_q - 1;
    if (k < 15) return '1;
    if (k < 30 || cur_q == 0) return rand64();
    return rand64() % cur_q;
  endfunction

  task automatic test_random(int n);
    logic [3:0] op;
    logic [63:0] acc;
    for (int i = 0; i < n; i++) begin
      op = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 12)) : 4'($urandom_range(11));
      acc = pick_operand();
      if ($urandom_range(3) == 0) acc = rand64();
      send_item(op, pick_operand(), pick_operand(), acc[62:0], 1'($urandom));
    end
  endtask

  task automatic test_directed();
    logic [63:0] qm1;
    qm1 = cur_q - 1;
    for (int op = 0; op < 16; op++) begin
      send_item(4'(op), qm1, qm1, qm1[62:0], 1'b1);
    end
    send_item(OP_MUL, '1, '1, '1, 1'b0);
    send_item(OP_MUL, 64'd0, '1, '0, 1'b1);
    send_item(OP_NEG, 64'd0, 64'd0, '0, 1'b0);
    send_item(OP_RED_S, 64'h8000_0000_0000_0000, 64'd0, '0, 1'b1);
    send_item(OP_RED_S, '1, 64'd0, '0, 1'b0);
    send_item(OP_RED, '1, 64'd0, '0, 1'b1);
    send_item(OP_SUB, 64'd0, qm1, '0, 1'b0);
    send_item(OP_SCALE, qm1, '1, '0, 1'b1);
    send_item(OP_MUL_SUB, qm1, qm1, '0, 1'b0);
  endtask

  // Hold the receiver off while the sender keeps pushing, then let it drain.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 300;
    test_random(120);
    drain();
  endtask

  task automatic test_idle_phases(int n);
    send_idle_pct = 0;  recv_stall_pct = 0;  test_random(n);
    send_idle_pct = 49; recv_stall_pct = 0;  test_random(n);
    send_idle_pct = 0;  recv_stall_pct = 49; test_random(n);
    send_idle_pct = 33; recv_stall_pct = 33; test_random(n);
  endtask

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    residue_t e;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_residues.size() == 0) begin
        $display("%0t: unexpected result residue=%h last=%b", $time, rsp.residue, rsp.last_out);
        err_count++;
      end else begin
        e = pending_residues.pop_front();
        if (rsp.residue !== e.residue) begin
          $display("%0t: residue expected %h actual %h", $time, e.residue, rsp.residue);
          err_count++;
        end
        if (rsp.last_out !== e.last) begin
          $display("%0t: last_out expected %b actual %b", $time, e.last, rsp.last_out);
          err_count++;
        end
      end
    end
  end

  initial begin
    #(12 * 2000000);
    $display("status: fail");
    $finish;
  end

  initial begin
    req.valid = 1'b0;
    req.operation = '0;
    req.operand_a = '0;
    req.operand_b = '0;
    req.accumulator = '0;
    req.last_in = 1'b0;
    rsp.ready = 1'b0;
    cur_q = 64'(MODULUS_RST);
    cur_factor = BFACTOR_RST;
    cur_shift = PSHIFT_RST;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_random(20);
    load_modulus(63'h7fff_ffff_ffff_ffe7);
    test_directed();
    test_idle_phases(30);
    test_backpressure();
    load_modulus(63'd3);
    test_directed();
    test_idle_phases(25);
    load_modulus(63'h0000_0000_ffff_fffb);
    test_idle_phases(25);
    load_modulus(63'd1000003);
    test_idle_phases(20);
    // Zero modulus: scalars pass through unreduced.
    write_register(REG_MODULUS, 64'd0);
    write_register(REG_BFACTOR, rand64());
    test_random(40);
    write_register(REG_MODULUS, 64'h7fff_ffff_ffff_ffff);
    write_register(REG_BFACTOR, '1);
    write_register(REG_PSHIFT, 64'd0);
    test_directed();
    test_random(40);
    write_register(REG_PSHIFT, 64'd63);
    test_random(40);
    write_register(REG_MODULUS, 64'd2);
    write_register(REG_BFACTOR, 64'd0);
    test_random(20);

    drain();
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
